FILE: rtl/tbpe_pkg.sv
// ---------------------------------------------------------------------------
// tbpe_pkg
// Shared constants, codes and controller/datapath handoff types for the
// block pool evictor.
// ---------------------------------------------------------------------------
package tbpe_pkg;

	localparam int POOL_DEPTH = 64;
	localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
	localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int CMP_W      = (CNT_W > 7) ? CNT_W : 7;

	localparam int CMD_W      = 2;
	localparam int SIZE_W     = 32;
	localparam int TTL_W      = 32;
	localparam int RIDX_W     = 6;
	localparam int STAT_W     = 2;
	localparam int OCNT_W     = 7;
	localparam int CAP_W      = 7;
	localparam int POL_W      = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

	localparam logic [POL_W-1:0] POL_NEVER    = 3'd0;
	localparam logic [POL_W-1:0] POL_NEWEST   = 3'd1;
	localparam logic [POL_W-1:0] POL_OLDEST   = 3'd2;
	localparam logic [POL_W-1:0] POL_RANDOM   = 3'd3;
	localparam logic [POL_W-1:0] POL_LARGEST  = 3'd4;
	localparam logic [POL_W-1:0] POL_SMALLEST = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 1'd1;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef struct packed {
		logic load;
		logic add;
		logic del_empty;
		logic del_setup;
		logic scan_start;
		logic scan;
		logic sweep_start;
		logic sweep;
		logic sweep_end;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             del_active;
		logic             by_size;
		logic             empty;
		logic             reads_done;
		logic             inflight;
	} dp_stat_t;

endpackage

FILE: rtl/tbpe_if.sv
// ---------------------------------------------------------------------------
// tbpe_req_if / tbpe_rsp_if
// Valid/ready channels for commands into and results out of the pool.
// ---------------------------------------------------------------------------
interface tbpe_req_if;
	logic                                valid;
	logic                                ready;
	logic [tbpe_pkg::CMD_W-1:0]          command;
	logic [tbpe_pkg::SIZE_W-1:0]         block_size;
	logic signed [tbpe_pkg::TTL_W-1:0]   block_ttl;
	logic [tbpe_pkg::RIDX_W-1:0]         random_index;

	modport source (output valid, command, block_size, block_ttl, random_index, input ready);
	modport sink (input valid, command, block_size, block_ttl, random_index, output ready);
endinterface

interface tbpe_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tbpe_pkg::STAT_W-1:0]   status;
	logic [tbpe_pkg::OCNT_W-1:0]   entry_count;
	logic [tbpe_pkg::SIZE_W-1:0]   removed_size;
	logic [tbpe_pkg::OCNT_W-1:0]   pruned_count;

	modport source (output valid, status, entry_count, removed_size, pruned_count, input ready);
	modport sink (input valid, status, entry_count, removed_size, pruned_count, output ready);
endinterface

FILE: rtl/tbpe_ctrl.sv
// ---------------------------------------------------------------------------
// tbpe_ctrl
// Command sequencer: decode, size scan, compaction sweep, result handoff.
// ---------------------------------------------------------------------------
module tbpe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  tbpe_pkg::dp_stat_t stat,
	output tbpe_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SWEEP,
		S_FIN
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   pass_done;

	assign pass_done = stat.reads_done && !stat.inflight;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = req_valid;
			end
			S_DECODE: begin
				case (stat.command)
					tbpe_pkg::CMD_ADD: begin
						cmd.add = 1'b1;
					end
					tbpe_pkg::CMD_DELETE: begin
						if (stat.del_active && stat.empty) begin
							cmd.del_empty = 1'b1;
						end else if (stat.del_active && stat.by_size) begin
							cmd.scan_start = 1'b1;
						end else if (stat.del_active) begin
							cmd.del_setup   = 1'b1;
							cmd.sweep_start = 1'b1;
						end
					end
					tbpe_pkg::CMD_TICK: begin
						cmd.sweep_start = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				if (pass_done) begin
					cmd.sweep_start = 1'b1;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_SWEEP: begin
				if (pass_done) begin
					cmd.sweep_end = 1'b1;
				end else begin
					cmd.sweep = 1'b1;
				end
			end
			S_FIN: begin
				cmd.publish = !rsp_valid_q || rsp_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.publish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (cmd.scan_start) begin
						state_q <= S_SCAN;
					end else if (cmd.sweep_start) begin
						state_q <= S_SWEEP;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (pass_done) state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (pass_done) state_q <= S_FIN;
				end
				S_FIN: begin
					if (cmd.publish) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/tbpe_datapath.sv
// ---------------------------------------------------------------------------
// tbpe_datapath
// Entry memory, held count, config registers, scan and compaction logic,
// result registers.
// ---------------------------------------------------------------------------
module tbpe_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [tbpe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tbpe_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic [tbpe_pkg::CMD_W-1:0]          command,
	input  logic [tbpe_pkg::SIZE_W-1:0]         block_size,
	input  logic signed [tbpe_pkg::TTL_W-1:0]   block_ttl,
	input  logic [tbpe_pkg::RIDX_W-1:0]         random_index,
	input  tbpe_pkg::dp_cmd_t                   cmd,
	output tbpe_pkg::dp_stat_t                  stat,
	output logic [tbpe_pkg::STAT_W-1:0]         status,
	output logic [tbpe_pkg::OCNT_W-1:0]         entry_count,
	output logic [tbpe_pkg::SIZE_W-1:0]         removed_size,
	output logic [tbpe_pkg::OCNT_W-1:0]         pruned_count
);

	localparam int ENT_W = tbpe_pkg::SIZE_W + tbpe_pkg::TTL_W;

	logic [ENT_W-1:0]                  entry_mem_q [tbpe_pkg::POOL_DEPTH];

	logic [tbpe_pkg::CAP_W-1:0]        cap_q;
	logic [tbpe_pkg::POL_W-1:0]        policy_q;
	logic [tbpe_pkg::CNT_W-1:0]        held_q;
	logic [tbpe_pkg::CNT_W-1:0]        rd_q;
	logic [tbpe_pkg::CNT_W-1:0]        wr_q;
	logic                              rv_s1;

	logic [tbpe_pkg::CMD_W-1:0]        cmd_q;
	logic [tbpe_pkg::SIZE_W-1:0]       size_q;
	logic [tbpe_pkg::TTL_W-1:0]        ttl_q;
	logic [tbpe_pkg::RIDX_W-1:0]       rindex_q;
	logic [tbpe_pkg::IDX_W-1:0]        pos_q;
	logic [tbpe_pkg::SIZE_W-1:0]       best_q;
	logic [tbpe_pkg::STAT_W-1:0]       res_status_q;
	logic [tbpe_pkg::SIZE_W-1:0]       removed_q;
	logic [tbpe_pkg::CNT_W-1:0]        pruned_q;
	logic [ENT_W-1:0]                  rdata_s1;
	logic [tbpe_pkg::IDX_W-1:0]        ridx_s1;

	logic [tbpe_pkg::STAT_W-1:0]       out_status_q;
	logic [tbpe_pkg::OCNT_W-1:0]       out_count_q;
	logic [tbpe_pkg::SIZE_W-1:0]       out_removed_q;
	logic [tbpe_pkg::OCNT_W-1:0]       out_pruned_q;

	logic                              full;
	logic                              is_tick;
	logic                              by_largest;
	logic                              rd_issue;
	logic [tbpe_pkg::IDX_W-1:0]        rd_addr;
	logic [tbpe_pkg::SIZE_W-1:0]       size_s1;
	logic [tbpe_pkg::TTL_W-1:0]        ttl_s1;
	logic [tbpe_pkg::TTL_W-1:0]        ttl_next;
	logic                              drop;
	logic                              better;
	logic                              mem_we;
	logic [tbpe_pkg::IDX_W-1:0]        mem_waddr;
	logic [ENT_W-1:0]                  mem_wdata;
	logic [tbpe_pkg::IDX_W-1:0]        setup_pos;
	logic                              keep_write;

	// effective capacity is min(register, depth)
	assign full = (tbpe_pkg::CMP_W'(held_q) >= tbpe_pkg::CMP_W'(cap_q))
		|| (held_q >= tbpe_pkg::CNT_W'(tbpe_pkg::POOL_DEPTH));

	assign is_tick    = (cmd_q == tbpe_pkg::CMD_TICK);
	assign by_largest = (policy_q == tbpe_pkg::POL_LARGEST);

	assign stat.command    = cmd_q;
	assign stat.del_active = (policy_q == tbpe_pkg::POL_NEWEST)
		|| (policy_q == tbpe_pkg::POL_OLDEST) || (policy_q == tbpe_pkg::POL_RANDOM)
		|| (policy_q == tbpe_pkg::POL_LARGEST) || (policy_q == tbpe_pkg::POL_SMALLEST);
	assign stat.by_size    = (policy_q == tbpe_pkg::POL_LARGEST)
		|| (policy_q == tbpe_pkg::POL_SMALLEST);
	assign stat.empty      = (held_q == '0);
	assign stat.reads_done = (rd_q >= held_q);
	assign stat.inflight   = rv_s1;

	assign rd_issue = (cmd.scan || cmd.sweep) && (rd_q < held_q);
	assign rd_addr  = rd_q[tbpe_pkg::IDX_W-1:0];

	assign size_s1  = rdata_s1[tbpe_pkg::SIZE_W-1:0];
	assign ttl_s1   = rdata_s1[ENT_W-1:tbpe_pkg::SIZE_W];
	// negative lifetimes never count down
	assign ttl_next = ((ttl_s1 != '0) && !ttl_s1[tbpe_pkg::TTL_W-1]) ? ttl_s1 - 1'b1 : ttl_s1;
	assign drop     = is_tick ? (ttl_next == '0) : (ridx_s1 == pos_q);
	assign better   = (ridx_s1 == '0)
		|| (by_largest ? (size_s1 > best_q) : (size_s1 < best_q));

	assign keep_write = cmd.sweep && rv_s1 && !drop;
	assign mem_we     = (cmd.add && !full) || keep_write;
	assign mem_waddr  = cmd.add ? held_q[tbpe_pkg::IDX_W-1:0] : wr_q[tbpe_pkg::IDX_W-1:0];
	assign mem_wdata  = cmd.add ? {ttl_q, size_q} : {(is_tick ? ttl_next : ttl_s1), size_s1};

	always_comb begin
		case (policy_q)
			tbpe_pkg::POL_NEWEST: begin
				setup_pos = tbpe_pkg::IDX_W'(held_q - 1'b1);
			end
			tbpe_pkg::POL_RANDOM: begin
				if (tbpe_pkg::CMP_W'(rindex_q) < tbpe_pkg::CMP_W'(held_q)) begin
					setup_pos = tbpe_pkg::IDX_W'(rindex_q);
				end else begin
					setup_pos = tbpe_pkg::IDX_W'(held_q - 1'b1);
				end
			end
			default: begin
				setup_pos = '0;
			end
		endcase
	end

	// entry storage: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) entry_mem_q[mem_waddr] <= mem_wdata;
		if (rd_issue) rdata_s1 <= entry_mem_q[rd_addr];
		ridx_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= tbpe_pkg::CAP_RESET;
			policy_q <= tbpe_pkg::POL_NEVER;
			held_q   <= '0;
			rd_q     <= '0;
			wr_q     <= '0;
			rv_s1    <= 1'b0;
		end else begin
			if (cfg_wr_en && (cfg_index == tbpe_pkg::CFG_CAPACITY)) begin
				cap_q <= cfg_wdata[tbpe_pkg::CAP_W-1:0];
			end
			if (cfg_wr_en && (cfg_index == tbpe_pkg::CFG_POLICY)) begin
				policy_q <= cfg_wdata[tbpe_pkg::POL_W-1:0];
			end
			rv_s1 <= rd_issue;
			if (cmd.add && !full) held_q <= held_q + 1'b1;
			if (cmd.sweep_end) held_q <= wr_q;
			if (cmd.scan_start || cmd.sweep_start) begin
				rd_q <= '0;
			end else if (rd_issue) begin
				rd_q <= rd_q + 1'b1;
			end
			if (cmd.sweep_start) begin
				wr_q <= '0;
			end else if (keep_write) begin
				wr_q <= wr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q        <= command;
			size_q       <= block_size;
			ttl_q        <= block_ttl;
			rindex_q     <= random_index;
			res_status_q <= tbpe_pkg::ST_OK;
			removed_q    <= '0;
			pruned_q     <= '0;
		end
		if (cmd.add && full) res_status_q <= tbpe_pkg::ST_FULL;
		if (cmd.del_empty) res_status_q <= tbpe_pkg::ST_EMPTY;
		if (cmd.del_setup) pos_q <= setup_pos;
		if (cmd.scan && rv_s1 && better) begin
			best_q <= size_s1;
			pos_q  <= ridx_s1;
		end
		if (cmd.sweep && rv_s1 && drop) begin
			if (is_tick) begin
				pruned_q <= pruned_q + 1'b1;
			end else begin
				removed_q <= size_s1;
			end
		end
		if (cmd.publish) begin
			out_status_q  <= res_status_q;
			out_count_q   <= tbpe_pkg::OCNT_W'(held_q);
			out_removed_q <= removed_q;
			out_pruned_q  <= tbpe_pkg::OCNT_W'(pruned_q);
		end
	end

	assign status       = out_status_q;
	assign entry_count  = out_count_q;
	assign removed_size = out_removed_q;
	assign pruned_count = out_pruned_q;

	a_held_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= tbpe_pkg::CNT_W'(tbpe_pkg::POOL_DEPTH))
		else $error("held count above pool depth");

	a_write_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep && rv_s1) |-> (wr_q <= tbpe_pkg::CNT_W'(ridx_s1)))
		else $error("compaction write pointer passed read data");

	a_sweep_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_end |-> (wr_q <= held_q))
		else $error("sweep grew the pool");

	a_add_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add |=> (held_q == $past(held_q) + tbpe_pkg::CNT_W'($past(!full))))
		else $error("add changed count wrongly");

endmodule

FILE: rtl/ttl_block_pool_evictor.sv
// Command flow: add, no-op, and delete under policy never or on an empty pool go
// straight from decode to the result; tick and delete by position (newest,
// oldest, index) run a compaction sweep; delete by largest or smallest size
// runs a read scan, then a compaction sweep; a stalled result delays the next.
// Throughput: one command at a time, set by the sweep at one entry per cycle;
// a new command is taken while a result waits. Reset: count zero, capacity 64,
// policy never; entry memory is not cleared.
// ---------------------------------------------------------------------------
// ttl_block_pool_evictor
// Ordered pool of sized blocks with lifetimes, eviction policy and expiry.
// ---------------------------------------------------------------------------
module ttl_block_pool_evictor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [tbpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbpe_pkg::CFG_DATA_W-1:0] cfg_wdata,
	tbpe_req_if.sink                        req,
	tbpe_rsp_if.source                      rsp
);

	tbpe_pkg::dp_cmd_t  cmd;
	tbpe_pkg::dp_stat_t stat;

	tbpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tbpe_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.command      (req.command),
		.block_size   (req.block_size),
		.block_ttl    (req.block_ttl),
		.random_index (req.random_index),
		.cmd          (cmd),
		.stat         (stat),
		.status       (rsp.status),
		.entry_count  (rsp.entry_count),
		.removed_size (rsp.removed_size),
		.pruned_count (rsp.pruned_count)
	);

endmodule
